// ===== rtl/pct_pkg.sv =====
// Shared types, constants and helpers for the pomodoro countdown timer.
package pct_pkg;

	localparam int unsigned MS_PER_MIN = 60000;

	localparam logic [6:0] WORK_MAX    = 7'd90;
	localparam logic [6:0] WORK_MIN    = 7'd1;
	localparam logic [6:0] WORK_RESET  = 7'd25;
	localparam logic [6:0] BREAK_RESET = 7'd5;
	localparam logic [7:0] CYCLE_MAX   = 8'd255;

	// event codes carried in the kind field
	typedef enum logic [2:0] {
		KIND_TICK  = 3'd0,
		KIND_START = 3'd1,
		KIND_RESET = 3'd2,
		KIND_UP    = 3'd3,
		KIND_DOWN  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_PAUSED  = 2'd2
	} run_mode_t;

	// timer state, also the bulk of each result
	typedef struct packed {
		run_mode_t   mode;
		logic [22:0] time_left;
		logic [31:0] last_stamp;
		logic        break_active;
		logic [7:0]  cycles;
		logic [6:0]  work_len;
	} pct_state_t;

	// minutes to milliseconds; 127 minutes still fits in 23 bits
	function automatic logic [22:0] min_to_ms(input logic [6:0] m);
		logic [22:0] r;
		r = 23'(m) * 23'(MS_PER_MIN);
		return r;
	endfunction

	localparam pct_state_t STATE_RESET = '{
		mode:         MODE_STOPPED,
		time_left:    23'(25 * MS_PER_MIN),
		last_stamp:   32'd0,
		break_active: 1'b0,
		cycles:       8'd0,
		work_len:     WORK_RESET
	};

endpackage

// ===== rtl/pct_if.sv =====
// Valid/ready channel interfaces for timer events and timer results.

interface pct_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] now;

	modport source (output valid, output kind, output now, input ready);
	modport sink   (input valid, input kind, input now, output ready);
endinterface

interface pct_out_if;
	logic        valid;
	logic        ready;
	logic [22:0] ms_left;
	logic [1:0]  run_state;
	logic        on_break;
	logic [7:0]  completed_cycles;
	logic [6:0]  work_minutes;
	logic        phase_changed;

	modport source (output valid, output ms_left, output run_state, output on_break,
		output completed_cycles, output work_minutes, output phase_changed, input ready);
	modport sink   (input valid, input ms_left, input run_state, input on_break,
		input completed_cycles, input work_minutes, input phase_changed, output ready);
endinterface

// ===== rtl/pct_next.sv =====
// Next-state logic: applies one event to the current timer state.
module pct_next (
	input  pct_pkg::pct_state_t cur,
	input  logic [2:0]          kind,
	input  logic [31:0]         now,
	input  logic [6:0]          break_minutes,
	output pct_pkg::pct_state_t nxt,
	output logic                flipped
);

	logic [31:0] dt;
	logic [6:0]  sel_min;
	logic        load;

	always_comb begin
		nxt     = cur;
		flipped = 1'b0;
		sel_min = cur.work_len;
		load    = 1'b0;
		dt      = now - cur.last_stamp;

		case (pct_pkg::kind_t'(kind))
			pct_pkg::KIND_TICK: begin
				// count down by the time since the last stamp
				if (cur.mode == pct_pkg::MODE_RUNNING) begin
					nxt.last_stamp = now;
					if (dt >= {9'd0, cur.time_left}) begin
						nxt.time_left = 23'd0;
						nxt.mode      = pct_pkg::MODE_STOPPED;
					end else begin
						nxt.time_left = cur.time_left - dt[22:0];
					end
				end
				// phase expired: flip and restart
				if (nxt.mode == pct_pkg::MODE_STOPPED && nxt.time_left == 23'd0) begin
					flipped          = 1'b1;
					nxt.break_active = ~cur.break_active;
					if (cur.break_active && cur.cycles < pct_pkg::CYCLE_MAX) begin
						nxt.cycles = cur.cycles + 8'd1;
					end
					sel_min        = cur.break_active ? cur.work_len : break_minutes;
					load           = 1'b1;
					nxt.mode       = pct_pkg::MODE_RUNNING;
					nxt.last_stamp = now;
				end
			end
			pct_pkg::KIND_START: begin
				if (cur.mode == pct_pkg::MODE_STOPPED) begin
					nxt.break_active = 1'b0;
					load             = 1'b1;
				end
				if (cur.mode == pct_pkg::MODE_RUNNING) begin
					nxt.mode = pct_pkg::MODE_PAUSED;
				end else begin
					nxt.mode       = pct_pkg::MODE_RUNNING;
					nxt.last_stamp = now;
				end
			end
			pct_pkg::KIND_RESET: begin
				nxt.mode         = pct_pkg::MODE_STOPPED;
				nxt.break_active = 1'b0;
				nxt.cycles       = 8'd0;
				load             = 1'b1;
			end
			pct_pkg::KIND_UP: begin
				if (cur.mode != pct_pkg::MODE_RUNNING && cur.work_len < pct_pkg::WORK_MAX) begin
					nxt.work_len = cur.work_len + 7'd1;
					sel_min      = nxt.work_len;
					load         = 1'b1;
				end
			end
			pct_pkg::KIND_DOWN: begin
				if (cur.mode != pct_pkg::MODE_RUNNING && cur.work_len > pct_pkg::WORK_MIN) begin
					nxt.work_len = cur.work_len - 7'd1;
					sel_min      = nxt.work_len;
					load         = 1'b1;
				end
			end
			default: begin
				// unknown event: state unchanged
			end
		endcase

		// one shared minutes-to-ms multiply for every reload
		if (load) begin
			nxt.time_left = pct_pkg::min_to_ms(sel_min);
		end
	end

endmodule

// ===== rtl/pomodoro_countdown_timer_core.sv =====
// Pomodoro countdown timer core: one result per event transfer.
// Each event passes through the input register and then the result register before its result is valid.
// Throughput: one event per cycle; a stalled output holds back the input stage.
// The next-state logic (the elapsed-time subtracts and compare, and one constant multiply) sets the cycle time.
// Reset: arst_n clears the timer to stopped, 25 work minutes, 5 break minutes, no cycles.
module pomodoro_countdown_timer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	pct_in_if.sink     in_ch,
	pct_out_if.source  out_ch
);

	logic                valid_s1;
	logic [2:0]          kind_s1;
	logic [31:0]         now_s1;
	logic [6:0]          break_min_q;
	pct_pkg::pct_state_t state_q;
	pct_pkg::pct_state_t state_nxt;
	logic                flipped;
	logic                out_valid_q;
	pct_pkg::pct_state_t res_q;
	logic                res_flip_q;
	logic                advance;

	// result register free or being drained this cycle
	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;

	pct_next u_next (
		.cur           (state_q),
		.kind          (kind_s1),
		.now           (now_s1),
		.break_minutes (break_min_q),
		.nxt           (state_nxt),
		.flipped       (flipped)
	);

	// break length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_min_q <= pct_pkg::BREAK_RESET;
		end else if (cfg_wr_en) begin
			break_min_q <= cfg_wr_data;
		end
	end

	// control: stage valids and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= pct_pkg::STATE_RESET;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (valid_s1 && advance) begin
				state_q <= state_nxt;
			end
		end
	end

	// input payload register
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kind_s1 <= in_ch.kind;
			now_s1  <= in_ch.now;
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q      <= state_nxt;
			res_flip_q <= flipped;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.ms_left          = res_q.time_left;
	assign out_ch.run_state        = res_q.mode;
	assign out_ch.on_break         = res_q.break_active;
	assign out_ch.completed_cycles = res_q.cycles;
	assign out_ch.work_minutes     = res_q.work_len;
	assign out_ch.phase_changed    = res_flip_q;

endmodule
